// File: design/upf_pkg.sv
package upf_pkg;

  // Frame geometry and header offsets, counted in bytes from the frame start.
  localparam int MaxFrameBytes = 2048;
  localparam int PosW          = 12;
  localparam int IndexW        = 11;

  localparam logic [PosW-1:0] PosMax      = 12'd4095;
  localparam logic [PosW-1:0] EtypePos    = 12'd13;
  localparam logic [PosW-1:0] IpOffEth    = 12'd14;
  localparam logic [PosW-1:0] IpOffPppoe  = 12'd22;

  // Offsets of the checked fields relative to the start of the IPv4 header.
  localparam logic [PosW-1:0] OffVerHl    = 12'd0;
  localparam logic [PosW-1:0] OffFrag     = 12'd7;
  localparam logic [PosW-1:0] OffProto    = 12'd9;
  localparam logic [PosW-1:0] OffSrcAddr  = 12'd15;
  localparam logic [PosW-1:0] OffDstAddr  = 12'd19;
  localparam logic [PosW-1:0] OffSrcPort  = 12'd21;
  localparam logic [PosW-1:0] OffDstPort  = 12'd23;
  localparam logic [PosW-1:0] OffPayload  = 12'd28;

  // Header values that a kept frame must carry.
  localparam logic [15:0] EtypeIpv4  = 16'h0800;
  localparam logic [15:0] EtypePppoe = 16'h8864;
  localparam logic [7:0]  IpVerHl    = 8'h45;
  localparam logic [7:0]  IpProtoUdp = 8'h11;
  localparam logic [15:0] IpFlagDf   = 16'h4000;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgSrcAddr = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDstAddr = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSrcPort = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDstPort = 3'd3;

  // Queue between the parser and the output stage.
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        data;
    logic [IndexW-1:0] index;
    logic              last;
  } item_t;

endpackage

// File: design/upf_front.sv
module upf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  upf_pkg::cfg_t cfg_i,
  input  logic          full_i,
  output logic          push_o,
  output upf_pkg::item_t item_o
);

  logic [upf_pkg::PosW-1:0]   pos_q, pos_d;
  logic                       pppoe_q;
  logic                       dropped_q;
  logic [31:0]                shift_q, shift_d;
  logic [upf_pkg::IndexW-1:0] count_q;

  logic                       accept;
  logic [15:0]                lo16;
  logic [upf_pkg::PosW-1:0]   ip_base;
  logic [upf_pkg::PosW-1:0]   rel;
  logic [upf_pkg::PosW-1:0]   hdr_end;
  logic                       in_range;
  logic                       pppoe_set;
  logic                       drop_set;
  logic                       emit;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Header field view: the newest byte joins the last three.
  assign shift_d  = {shift_q[23:0], in_byte_i};
  assign lo16     = shift_d[15:0];
  assign ip_base  = pppoe_q ? upf_pkg::IpOffPppoe : upf_pkg::IpOffEth;
  assign rel      = pos_q - ip_base;
  assign hdr_end  = ip_base + upf_pkg::OffPayload;
  assign in_range = {20'd0, pos_q} < 32'(upf_pkg::MaxFrameBytes);

  // Classify the current byte: header check, payload byte or neither.
  always_comb begin
    pppoe_set = 1'b0;
    drop_set  = 1'b0;
    emit      = 1'b0;
    priority if (pos_q == upf_pkg::EtypePos) begin
      if (lo16 == upf_pkg::EtypePppoe) begin
        pppoe_set = 1'b1;
      end else if (lo16 != upf_pkg::EtypeIpv4) begin
        drop_set = 1'b1;
      end
    end else if (rel == upf_pkg::OffVerHl) begin
      drop_set = (in_byte_i != upf_pkg::IpVerHl);
    end else if (rel == upf_pkg::OffFrag) begin
      drop_set = (lo16 != 16'h0000) && (lo16 != upf_pkg::IpFlagDf);
    end else if (rel == upf_pkg::OffProto) begin
      drop_set = (in_byte_i != upf_pkg::IpProtoUdp);
    end else if (rel == upf_pkg::OffSrcAddr) begin
      drop_set = (cfg_i.src_addr != 32'd0) && (shift_d != cfg_i.src_addr);
    end else if (rel == upf_pkg::OffDstAddr) begin
      drop_set = (cfg_i.dst_addr != 32'd0) && (shift_d != cfg_i.dst_addr);
    end else if (rel == upf_pkg::OffSrcPort) begin
      drop_set = (cfg_i.src_port != 16'd0) && (lo16 != cfg_i.src_port);
    end else if (rel == upf_pkg::OffDstPort) begin
      drop_set = (cfg_i.dst_port != 16'd0) && (lo16 != cfg_i.dst_port);
    end else begin
      emit = (pos_q >= hdr_end) && !dropped_q && in_range;
    end
  end

  // Byte position saturates so that very long frames keep a stable count.
  assign pos_d = (pos_q < upf_pkg::PosMax) ? pos_q + 12'd1 : pos_q;

  // Per-frame state, cleared after the byte that ends the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pppoe_q   <= 1'b0;
      dropped_q <= 1'b0;
      shift_q   <= '0;
      count_q   <= '0;
    end else if (accept) begin
      if (in_last_i) begin
        pos_q     <= '0;
        pppoe_q   <= 1'b0;
        dropped_q <= 1'b0;
        shift_q   <= '0;
        count_q   <= '0;
      end else begin
        pos_q     <= pos_d;
        pppoe_q   <= pppoe_q | pppoe_set;
        dropped_q <= dropped_q | drop_set;
        shift_q   <= shift_d;
        if (emit) begin
          count_q <= count_q + 11'd1;
        end
      end
    end
  end

  // Payload bytes go into the queue together with their index and last flag.
  assign push_o       = accept && emit;
  assign item_o.data  = in_byte_i;
  assign item_o.index = count_q;
  assign item_o.last  = in_last_i;

endmodule

// File: design/upf_fifo.sv
module upf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  upf_pkg::item_t wdata_i,
  input  logic           pop_i,
  output upf_pkg::item_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  upf_pkg::item_t                mem_q [upf_pkg::FifoDepth];
  logic [upf_pkg::FifoPtrW-1:0]  wr_ptr_q;
  logic [upf_pkg::FifoPtrW-1:0]  rd_ptr_q;
  logic [upf_pkg::FifoCntW-1:0]  cnt_q;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_q == upf_pkg::FifoCntW'(upf_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers wrap at the queue depth; the count tracks the fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == upf_pkg::FifoPtrW'(upf_pkg::FifoDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == upf_pkg::FifoPtrW'(upf_pkg::FifoDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: design/upf_back.sv
module upf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  input  upf_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 out_byte_o,
  output logic [upf_pkg::IndexW-1:0] out_index_o,
  output logic                       out_last_o
);

  logic           valid_q;
  upf_pkg::item_t item_q;

  // Load the output register whenever it is empty or being taken.
  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = item_q.data;
  assign out_index_o = item_q.index;
  assign out_last_o  = item_q.last;

endmodule

// File: design/udp_payload_filter_core.sv
// Ethernet/IPv4/UDP payload filter.
// Input channel: one frame byte per transaction (frame_byte_i, frame_last_i on
// the final byte), Ethernet header first, with optional PPPoE/PPP headers.
// Output channel: one transaction per UDP payload byte among the first 2048 bytes
// of a kept frame, with its payload index and the frame byte's last flag.
// Headers are checked on the fly; the match registers (zero accepts any) are
// written through cfg_we_i/cfg_index_i/cfg_wdata_i, which the user must do only
// while no frame is in flight; the block itself does not enforce this. Each
// channel moves one byte per cycle while payload_ready_i is high; header bytes
// and dropped frames produce nothing.
// The parser pushes payload bytes into a four-entry queue that feeds the
// output register. When the receiver stalls, the output register holds and
// the queue fills; frame_ready_o falls only once all four entries are taken.
// Reset clears the match registers, the per-frame parser state, the queue and
// the output valid; the block accepts bytes as soon as reset is released.
module udp_payload_filter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         frame_valid_i,
  output logic                         frame_ready_o,
  input  logic [7:0]                   frame_byte_i,
  input  logic                         frame_last_i,
  output logic                         payload_valid_o,
  input  logic                         payload_ready_i,
  output logic [7:0]                   payload_byte_o,
  output logic [upf_pkg::IndexW-1:0]   payload_index_o,
  output logic                         payload_last_o,
  input  logic                         cfg_we_i,
  input  logic [upf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_wdata_i
);

  upf_pkg::cfg_t  cfg_q;
  upf_pkg::item_t push_item;
  upf_pkg::item_t pop_item;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  // Match registers; writes to unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        upf_pkg::CfgSrcAddr: cfg_q.src_addr <= cfg_wdata_i;
        upf_pkg::CfgDstAddr: cfg_q.dst_addr <= cfg_wdata_i;
        upf_pkg::CfgSrcPort: cfg_q.src_port <= cfg_wdata_i[15:0];
        upf_pkg::CfgDstPort: cfg_q.dst_port <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  upf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (frame_valid_i),
    .in_ready_o (frame_ready_o),
    .in_byte_i  (frame_byte_i),
    .in_last_i  (frame_last_i),
    .cfg_i      (cfg_q),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  upf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (pop_item),
    .full_o  (full),
    .empty_o (empty)
  );

  upf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (payload_valid_o),
    .out_ready_i (payload_ready_i),
    .out_byte_o  (payload_byte_o),
    .out_index_o (payload_index_o),
    .out_last_o  (payload_last_o)
  );

endmodule

// File: design/upf_checker.sv
module upf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         frame_valid_i,
  input logic                         frame_ready_o,
  input logic                         payload_valid_o,
  input logic                         payload_ready_i,
  input logic [7:0]                   payload_byte_o,
  input logic [upf_pkg::IndexW-1:0]   payload_index_o,
  input logic                         payload_last_o
);

  // A stalled payload transaction keeps its valid and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    payload_valid_o && !payload_ready_i |=>
      payload_valid_o && $stable(payload_byte_o) && $stable(payload_index_o) &&
      $stable(payload_last_o))
    else $error("payload transaction changed while stalled");

  // The input side only backs up once the output register is occupied.
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_ready_o |-> payload_valid_o)
    else $error("frame input stalled with an empty output register");

  // A fresh output transaction comes from a frame byte that went through the queue.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(payload_valid_o) |-> $past(frame_valid_i && frame_ready_o, 2))
    else $error("payload appeared without a matching frame byte");

  // Nothing is presented right after reset is released.
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !payload_valid_o)
    else $error("payload valid right after reset");

endmodule

bind udp_payload_filter_core upf_checker u_upf_checker (.*);
